@@ hdl/wrs_pkg.sv @@
// Package for the watchdog reset sequencer: sequencer phase codes, register
// indexes, reset values and the control word passed to the watchdog counter.
// No dependencies.
package wrs_pkg;

   // Configuration port geometry.
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CSR_IDX_W  = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OVERFLOWS_PER_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_COUNT       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOT_DELAY_MS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MS              = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MS            = 3'd4;

   // Configuration reset values.
   localparam logic [7:0]  RST_OVERFLOWS_PER_COUNT = 8'd38;
   localparam logic [7:0]  RST_TIMEOUT_COUNT       = 8'd35;
   localparam logic [15:0] RST_BOOT_DELAY_MS       = 16'd1000;
   localparam logic [15:0] RST_GAP_MS              = 16'd150;
   localparam logic [7:0]  RST_PULSE_MS            = 8'd1;

   // Largest watchdog count; the count saturates here.
   localparam logic [7:0] WD_COUNT_MAX = 8'hFF;

   // Sequencer phases, one-hot.
   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_BOOT   = 5'b00010,
      PH_PULSE1 = 5'b00100,
      PH_GAP    = 5'b01000,
      PH_PULSE2 = 5'b10000
   } phase_type;

   // Control word from the sequencer to the watchdog counter.
   typedef struct packed {
      logic step;       // a word is being processed and counting is enabled
      logic overflow;   // timer overflow tick of that word
      logic heartbeat;  // heartbeat edge of that word
      logic clear;      // end of a reset sequence: count returns to zero
   } cnt_ctrl_type;

endpackage

@@ hdl/watchdog_reset_sequencer.sv @@
// Watchdog reset sequencer, top level: input register, sequencer, result register.
// A word accepted into the input register moves on to the result register once that
// register can take it. Throughput: one word per cycle while the receiver does not stall;
// the input and result registers let a new word enter while the previous result waits to be taken.
// Reset (synchronous): registers return to defaults and the power-up sequence starts.
// Depends on wrs_pkg and wrs_counter.
module watchdog_reset_sequencer #(
   parameter int unsigned DELAY_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input word channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_overflow_tick,
   input  logic                             req_ms_tick,
   input  logic                             req_heartbeat,
   // Result word channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_esp_reset,
   output logic                             rsp_lte_reset,
   output logic [7:0]                       rsp_watchdog_count,
   output logic                             rsp_sequence_active,
   // Configuration write port
   input  logic                             csr_wr_en,
   input  logic [wrs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wrs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // The phase timer is compared against 16-bit phase lengths, so the compare
   // is done at whichever width is larger.
   localparam int unsigned CMP_W = (DELAY_WIDTH > 16) ? DELAY_WIDTH : 16;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes must arrive only while the block is idle; the block does not enforce this.
   // ---------------------------------------------------------------------
   logic [7:0]  cfg_ovf_ff;
   logic [7:0]  cfg_timeout_ff;
   logic [15:0] cfg_boot_ff;
   logic [15:0] cfg_gap_ff;
   logic [7:0]  cfg_pulse_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ovf_ff     <= wrs_pkg::RST_OVERFLOWS_PER_COUNT;
         cfg_timeout_ff <= wrs_pkg::RST_TIMEOUT_COUNT;
         cfg_boot_ff    <= wrs_pkg::RST_BOOT_DELAY_MS;
         cfg_gap_ff     <= wrs_pkg::RST_GAP_MS;
         cfg_pulse_ff   <= wrs_pkg::RST_PULSE_MS;
      end else if (csr_wr_en) begin
         case (csr_index)
            wrs_pkg::CSR_OVERFLOWS_PER_COUNT: cfg_ovf_ff     <= csr_wdata[7:0];
            wrs_pkg::CSR_TIMEOUT_COUNT:       cfg_timeout_ff <= csr_wdata[7:0];
            wrs_pkg::CSR_BOOT_DELAY_MS:       cfg_boot_ff    <= csr_wdata[15:0];
            wrs_pkg::CSR_GAP_MS:              cfg_gap_ff     <= csr_wdata[15:0];
            wrs_pkg::CSR_PULSE_MS:            cfg_pulse_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input register. A word waits here until the result register can take
   // its result; the state is updated at that same edge.
   // ---------------------------------------------------------------------
   logic in_valid_ff, in_valid_in;
   logic in_ovf_ff, in_ms_ff, in_hb_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ovf_ff <= req_overflow_tick;
         in_ms_ff  <= req_ms_tick;
         in_hb_ff  <= req_heartbeat;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer state.
   // ---------------------------------------------------------------------
   wrs_pkg::phase_type     phase_ff, phase_in;
   logic [DELAY_WIDTH-1:0] timer_ff, timer_in;
   logic                   powerup_ff, powerup_in;

   logic [DELAY_WIDTH-1:0] timer_inc;
   logic [15:0]            phase_len;
   logic                   phase_done;
   logic                   seq_end;
   logic [7:0]             count_next;
   wrs_pkg::cnt_ctrl_type  cnt_ctrl;

   // An ms tick moves the timer on, but it stops at its largest value.
   assign timer_inc = (in_ms_ff && (timer_ff != {DELAY_WIDTH{1'b1}}))
                      ? timer_ff + DELAY_WIDTH'(1) : timer_ff;

   always_comb begin
      case (phase_ff)
         wrs_pkg::PH_BOOT:   phase_len = cfg_boot_ff;
         wrs_pkg::PH_PULSE1: phase_len = {8'd0, cfg_pulse_ff};
         wrs_pkg::PH_GAP:    phase_len = cfg_gap_ff;
         default:            phase_len = {8'd0, cfg_pulse_ff};
      endcase
   end

   assign phase_done = CMP_W'(timer_inc) >= CMP_W'(phase_len);
   // The sequence ends when the second pulse has lasted its full length.
   assign seq_end    = (phase_ff == wrs_pkg::PH_PULSE2) && phase_done;

   // Counting is held through the power-up sequence.
   assign cnt_ctrl.step      = advance && !powerup_ff;
   assign cnt_ctrl.overflow  = in_ovf_ff;
   assign cnt_ctrl.heartbeat = in_hb_ff;
   assign cnt_ctrl.clear     = seq_end;

   wrs_counter u_counter (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (cnt_ctrl),
      .overflows_per_count (cfg_ovf_ff),
      .update              (advance),
      .count_next          (count_next)
   );

   always_comb begin
      phase_in   = phase_ff;
      timer_in   = timer_ff;
      powerup_in = powerup_ff;
      case (phase_ff)
         wrs_pkg::PH_BOOT, wrs_pkg::PH_PULSE1, wrs_pkg::PH_GAP, wrs_pkg::PH_PULSE2: begin
            timer_in = timer_inc;
            if (phase_done) begin
               timer_in = '0;
               case (phase_ff)
                  wrs_pkg::PH_BOOT:   phase_in = wrs_pkg::PH_PULSE1;
                  wrs_pkg::PH_PULSE1: phase_in = wrs_pkg::PH_GAP;
                  wrs_pkg::PH_GAP:    phase_in = wrs_pkg::PH_PULSE2;
                  default: begin
                     phase_in   = wrs_pkg::PH_IDLE;
                     powerup_in = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            // Idle: the count after this word's update is checked against the
            // timeout. A sequence that just ended can restart one word later.
            phase_in = wrs_pkg::PH_IDLE;
            if (count_next == cfg_timeout_ff) begin
               phase_in = wrs_pkg::PH_BOOT;
               timer_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= wrs_pkg::PH_BOOT;
         timer_ff   <= '0;
         powerup_ff <= 1'b1;
      end else if (advance) begin
         phase_ff   <= phase_in;
         timer_ff   <= timer_in;
         powerup_ff <= powerup_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register. It holds while the receiver stalls.
   // ---------------------------------------------------------------------
   logic       out_esp_ff, out_lte_ff, out_active_ff;
   logic [7:0] out_count_ff;

   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_esp_ff    <= (phase_in == wrs_pkg::PH_PULSE1);
         out_lte_ff    <= (phase_in == wrs_pkg::PH_PULSE2);
         out_count_ff  <= count_next;
         out_active_ff <= (phase_in != wrs_pkg::PH_IDLE);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_esp_reset       = out_esp_ff;
   assign rsp_lte_reset       = out_lte_ff;
   assign rsp_watchdog_count  = out_count_ff;
   assign rsp_sequence_active = out_active_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // The two reset pulses never overlap.
   a_pulses_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_esp_reset && rsp_lte_reset))
      else $error("both reset pulses active in one result word");

   // A reset pulse is only reported inside a running sequence.
   a_pulse_in_sequence: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_esp_reset || rsp_lte_reset)) |-> rsp_sequence_active)
      else $error("reset pulse outside a sequence");

   // Counting is held during the power-up sequence, so the count stays zero.
   a_powerup_count_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && powerup_ff) |-> (count_next == 8'd0))
      else $error("watchdog count moved during the power-up sequence");

   // A word held in the input register is not lost while the output stalls.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input word dropped while stalled");

endmodule

@@ hdl/wrs_counter.sv @@
// Watchdog counter: overflow prescaler, saturating count and heartbeat clear.
// Depends on wrs_pkg.
module wrs_counter (
   input  logic                clock,
   input  logic                reset,
   input  wrs_pkg::cnt_ctrl_type ctrl,
   input  logic [7:0]          overflows_per_count,
   input  logic                update,
   output logic [7:0]          count_next
);

   logic [7:0] prescale_ff, prescale_in;
   logic [7:0] count_ff;
   logic [7:0] limit;
   logic [8:0] pre_inc;
   logic [7:0] count_stepped;

   // A prescaler setting of zero behaves as one.
   assign limit   = (overflows_per_count == 8'd0) ? 8'd1 : overflows_per_count;
   assign pre_inc = {1'b0, prescale_ff} + 9'd1;

   always_comb begin
      prescale_in   = prescale_ff;
      count_stepped = count_ff;
      if (ctrl.step && ctrl.overflow) begin
         if (pre_inc >= {1'b0, limit}) begin
            prescale_in = 8'd0;
            if (count_ff != wrs_pkg::WD_COUNT_MAX) begin
               count_stepped = count_ff + 8'd1;
            end
         end else begin
            prescale_in = pre_inc[7:0];
         end
      end
      if (ctrl.step && ctrl.heartbeat) begin
         count_stepped = 8'd0;
      end
   end

   // The end-of-sequence clear wins over everything else in the same word.
   assign count_next = ctrl.clear ? 8'd0 : count_stepped;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= 8'd0;
         count_ff    <= 8'd0;
      end else if (update) begin
         prescale_ff <= prescale_in;
         count_ff    <= count_next;
      end
   end

endmodule

@@ verif/wrs_sequencer_checker.sv @@
// Checker for the watchdog reset sequencer: watches the input, result and register
// channels, predicts every result word and compares it with what the block returns.
// Depends on wrs_pkg for the phase codes, register indexes and reset values.
module wrs_sequencer_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic                             req_overflow_tick,
   input  logic                             req_ms_tick,
   input  logic                             req_heartbeat,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             rsp_esp_reset,
   input  logic                             rsp_lte_reset,
   input  logic [7:0]                       rsp_watchdog_count,
   input  logic                             rsp_sequence_active,
   input  logic                             csr_wr_en,
   input  logic [wrs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wrs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int unsigned                      mismatch_count,
   output int unsigned                      pending_words
);

   typedef struct packed {
      logic       esp_reset;
      logic       lte_reset;
      logic [7:0] watchdog_count;
      logic       sequence_active;
   } sequencer_word_type;

   // Register copies.
   logic [7:0]  cfg_per_count;
   logic [7:0]  cfg_timeout;
   logic [15:0] cfg_boot_ms;
   logic [15:0] cfg_gap_ms;
   logic [7:0]  cfg_pulse_ms;

   // Predicted sequencer and watchdog state.
   wrs_pkg::phase_type seq_phase;
   logic [15:0]        seq_timer;
   logic [7:0]         prescale;
   logic [7:0]         wd_count;
   logic               powerup_run;

   sequencer_word_type expected_words[$];
   int unsigned        errors;

   // Advances the predicted state by one input word and returns the result word.
   function automatic sequencer_word_type step_sequencer(input logic ovf, input logic ms,
                                                         input logic hb);
      logic [7:0]         limit;
      logic [8:0]         next_pre;
      logic [15:0]        span;
      sequencer_word_type word;
      if (!powerup_run) begin
         if (ovf) begin
            limit = (cfg_per_count == 8'd0) ? 8'd1 : cfg_per_count;
            next_pre = {1'b0, prescale} + 9'd1;
            if (next_pre >= {1'b0, limit}) begin
               prescale = 8'd0;
               if (wd_count != wrs_pkg::WD_COUNT_MAX) wd_count = wd_count + 8'd1;
            end else begin
               prescale = next_pre[7:0];
            end
         end
         if (hb) wd_count = 8'd0;
      end
      if (seq_phase != wrs_pkg::PH_IDLE) begin
         if (ms && seq_timer != 16'hFFFF) seq_timer = seq_timer + 16'd1;
         case (seq_phase)
            wrs_pkg::PH_BOOT: span = cfg_boot_ms;
            wrs_pkg::PH_GAP:  span = cfg_gap_ms;
            default:          span = {8'd0, cfg_pulse_ms};
         endcase
         if (seq_timer >= span) begin
            seq_timer = 16'd0;
            case (seq_phase)
               wrs_pkg::PH_BOOT:   seq_phase = wrs_pkg::PH_PULSE1;
               wrs_pkg::PH_PULSE1: seq_phase = wrs_pkg::PH_GAP;
               wrs_pkg::PH_GAP:    seq_phase = wrs_pkg::PH_PULSE2;
               default: begin
                  seq_phase = wrs_pkg::PH_IDLE;
                  wd_count = 8'd0;
                  powerup_run = 1'b0;
               end
            endcase
         end
      end else if (wd_count == cfg_timeout) begin
         seq_phase = wrs_pkg::PH_BOOT;
         seq_timer = 16'd0;
      end
      word.esp_reset       = (seq_phase == wrs_pkg::PH_PULSE1);
      word.lte_reset       = (seq_phase == wrs_pkg::PH_PULSE2);
      word.watchdog_count  = wd_count;
      word.sequence_active = (seq_phase != wrs_pkg::PH_IDLE);
      return word;
   endfunction

   always @(posedge clock) begin
      sequencer_word_type want;
      if (reset) begin
         cfg_per_count = wrs_pkg::RST_OVERFLOWS_PER_COUNT;
         cfg_timeout   = wrs_pkg::RST_TIMEOUT_COUNT;
         cfg_boot_ms   = wrs_pkg::RST_BOOT_DELAY_MS;
         cfg_gap_ms    = wrs_pkg::RST_GAP_MS;
         cfg_pulse_ms  = wrs_pkg::RST_PULSE_MS;
         seq_phase     = wrs_pkg::PH_BOOT;
         seq_timer     = 16'd0;
         prescale      = 8'd0;
         wd_count      = 8'd0;
         powerup_run   = 1'b1;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: result word arrived with none expected", $time);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_esp_reset !== want.esp_reset) begin
                  $display("%0t: esp_reset expected %0d, got %0d", $time,
                           want.esp_reset, rsp_esp_reset);
                  errors++;
               end
               if (rsp_lte_reset !== want.lte_reset) begin
                  $display("%0t: lte_reset expected %0d, got %0d", $time,
                           want.lte_reset, rsp_lte_reset);
                  errors++;
               end
               if (rsp_watchdog_count !== want.watchdog_count) begin
                  $display("%0t: watchdog_count expected %0d, got %0d", $time,
                           want.watchdog_count, rsp_watchdog_count);
                  errors++;
               end
               if (rsp_sequence_active !== want.sequence_active) begin
                  $display("%0t: sequence_active expected %0d, got %0d", $time,
                           want.sequence_active, rsp_sequence_active);
                  errors++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               wrs_pkg::CSR_OVERFLOWS_PER_COUNT: cfg_per_count = csr_wdata[7:0];
               wrs_pkg::CSR_TIMEOUT_COUNT:       cfg_timeout   = csr_wdata[7:0];
               wrs_pkg::CSR_BOOT_DELAY_MS:       cfg_boot_ms   = csr_wdata;
               wrs_pkg::CSR_GAP_MS:              cfg_gap_ms    = csr_wdata;
               wrs_pkg::CSR_PULSE_MS:            cfg_pulse_ms  = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_words.push_back(step_sequencer(req_overflow_tick, req_ms_tick,
                                                    req_heartbeat));
      end
      pending_words  <= expected_words.size();
      mismatch_count <= errors;
   end

endmodule

@@ verif/watchdog_reset_sequencer_tb.sv @@
// Top of the watchdog reset sequencer testbench: clock, reset, word and register
// stimulus, receiver stalls and the verdict. Depends on wrs_pkg, the block itself
// and wrs_sequencer_checker, which predicts and compares the result words.
module watchdog_reset_sequencer_tb;

   // An index that maps to no register; a write there must change nothing.
   localparam logic [wrs_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = wrs_pkg::CSR_PULSE_MS + 3'd1;
   // Generous bound on the whole run, in clock cycles.
   localparam int unsigned CYCLE_LIMIT = 200000;
   // Length of the long receiver hold-off, in cycles.
   localparam int unsigned HOLD_CYCLES = 60;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_overflow_tick = 1'b0;
   logic                           req_ms_tick = 1'b0;
   logic                           req_heartbeat = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_esp_reset;
   logic                           rsp_lte_reset;
   logic [7:0]                     rsp_watchdog_count;
   logic                           rsp_sequence_active;
   logic                           csr_wr_en = 1'b0;
   logic [wrs_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [wrs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned mismatch_count;
   int unsigned pending_words;

   // Idle and stall rates in percent; the stimulus sets them for each phase.
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // The stimulus asks for a long hold-off by bumping hold_requests; the receiver
   // process serves each request once and counts the cycles itself.
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;

   watchdog_reset_sequencer uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_overflow_tick   (req_overflow_tick),
      .req_ms_tick         (req_ms_tick),
      .req_heartbeat       (req_heartbeat),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_esp_reset       (rsp_esp_reset),
      .rsp_lte_reset       (rsp_lte_reset),
      .rsp_watchdog_count  (rsp_watchdog_count),
      .rsp_sequence_active (rsp_sequence_active),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   wrs_sequencer_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_overflow_tick   (req_overflow_tick),
      .req_ms_tick         (req_ms_tick),
      .req_heartbeat       (req_heartbeat),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_esp_reset       (rsp_esp_reset),
      .rsp_lte_reset       (rsp_lte_reset),
      .rsp_watchdog_count  (rsp_watchdog_count),
      .rsp_sequence_active (rsp_sequence_active),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .pending_words       (pending_words)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The receiver stalls at the current rate, except during a requested hold-off,
   // when it stalls without a break so that the block fills and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served = holds_served + 1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offers one word and returns at the edge where it is taken. Valid stays high on
   // return, so back-to-back words never lower and raise it in the same step; it only
   // drops when the sender decides to idle before the next word.
   task automatic send_word(input logic ovf, input logic ms, input logic hb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_overflow_tick <= ovf;
      req_ms_tick       <= ms;
      req_heartbeat     <= hb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drops valid and waits until every expected result word has arrived. The first
   // edge lets the checker count the word taken in the current step.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [wrs_pkg::CSR_IDX_W-1:0] index,
                            input logic [wrs_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Writes all registers while the block is idle. The eight-bit registers get random
   // upper bits, which the block must drop, and a stray write goes to an unmapped index.
   task automatic program_registers(input logic [7:0] per_count, input logic [7:0] timeout,
                                    input logic [15:0] boot_ms, input logic [15:0] gap_ms,
                                    input logic [7:0] pulse_ms);
      logic [7:0] junk;
      drain_results();
      // Let any work still in flight settle before the writes.
      repeat (2) @(posedge clock);
      junk = 8'($urandom_range(255));
      write_reg(wrs_pkg::CSR_OVERFLOWS_PER_COUNT, {junk, per_count});
      junk = 8'($urandom_range(255));
      write_reg(wrs_pkg::CSR_TIMEOUT_COUNT, {junk, timeout});
      write_reg(wrs_pkg::CSR_BOOT_DELAY_MS, boot_ms);
      write_reg(wrs_pkg::CSR_GAP_MS, gap_ms);
      junk = 8'($urandom_range(255));
      write_reg(wrs_pkg::CSR_PULSE_MS, {junk, pulse_ms});
      write_reg(CSR_UNMAPPED, wrs_pkg::CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Random words with the given tick rates. Heartbeats are kept rare so that the
   // count can climb to the timeout and start sequences. With long_hold set, the
   // receiver is asked for a long hold-off halfway through.
   task automatic run_random(input int count, input int ovf_pct, input int ms_pct,
                             input int hb_pct, input bit long_hold);
      for (int n = 0; n < count; n++) begin
         if (long_hold && n == count / 2) hold_requests = hold_requests + 1;
         send_word($urandom_range(99) < ovf_pct, $urandom_range(99) < ms_pct,
                   $urandom_range(99) < hb_pct);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every tick combination during the power-up run, with the reset settings:
      // counting and heartbeats must be held while that run lasts.
      for (int combo = 0; combo < 8; combo++)
         send_word(combo[0], combo[1], combo[2]);

      // Zero-length phases end the power-up run one phase per word. A prescaler of
      // zero acts as one, so every overflow steps the count; a heartbeat on the same
      // word as an overflow still leaves the count at zero. Reaching the timeout of
      // two then starts a watchdog-triggered run.
      program_registers(8'd0, 8'd2, 16'd0, 16'd0, 8'd0);
      repeat (5) send_word(1'b0, 1'b0, 1'b0);
      send_word(1'b1, 1'b0, 1'b0);
      send_word(1'b1, 1'b0, 1'b1);
      send_word(1'b1, 1'b0, 1'b0);
      send_word(1'b1, 1'b1, 1'b0);
      repeat (5) send_word(1'b0, 1'b1, 1'b0);

      // Short sequences, back to back, with no idling on either side.
      program_registers(8'd1, 8'd4, 16'd2, 16'd1, 8'd1);
      run_random(250, 60, 50, 3, 1'b0);

      // Sender idle most of the time.
      send_idle_pct = 67;
      program_registers(8'd3, 8'd6, 16'd5, 16'd3, 8'd2);
      run_random(250, 70, 40, 5, 1'b0);

      // Receiver stalling most of the time, plus one long hold-off while the sender
      // keeps offering words.
      send_idle_pct = 0;
      rsp_stall_pct = 67;
      program_registers(8'd2, 8'd5, 16'd1, 16'd2, 8'd3);
      run_random(250, 60, 50, 4, 1'b1);

      // An overflow on every word and no heartbeat: the count reaches the largest
      // timeout, and counting on through the long boot delay pins it at its maximum.
      send_idle_pct = 13;
      rsp_stall_pct = 13;
      program_registers(8'd1, 8'd255, 16'd300, 16'd1, 8'd1);
      run_random(300, 100, 20, 0, 1'b0);

      // Largest prescaler and phase lengths.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      program_registers(8'd255, 8'd1, 16'hFFFF, 16'hFFFF, 8'd255);
      run_random(150, 90, 50, 2, 1'b0);

      // A timeout of zero: the count is zero after each sequence, so the next word starts
      // another unless it steps the count away from zero. All phases are zero-length here as well.
      send_idle_pct = 13;
      rsp_stall_pct = 13;
      program_registers(8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
      run_random(150, 50, 50, 10, 1'b0);

      // Mixed settings with heavy idling on both sides.
      send_idle_pct = 67;
      rsp_stall_pct = 67;
      program_registers(8'd2, 8'd3, 16'd4, 16'd2, 8'd2);
      run_random(200, 60, 50, 3, 1'b0);

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
